// File: design/rr_pkg.sv
// Package for the fraction reducer: status codes and the command and status
// structs between controller and datapath. No dependencies.
`default_nettype none

package rr_pkg;

	localparam int unsigned STATUS_W = 2;

	localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_ZERO_DEN = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_MOST_NEG = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic load;          // capture a new transaction
		logic gcd_step;      // one binary GCD step
		logic gcd_fin;       // form the GCD, start the numerator division
		logic div_step;      // one restoring division step
		logic div_init_den;  // keep numerator quotient, start denominator division
		logic out_load;      // load the output register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic err;       // captured transaction is an error case
		logic gcd_done;  // one GCD operand has reached zero
		logic div_last;  // current division step is the last one
	} sts_t;

endpackage

`default_nettype wire

// File: design/rr_ctrl.sv
// Controller of the fraction reducer: sequences GCD, two divisions and output.
// Depends on rr_pkg (cmd_t, sts_t).
`default_nettype none

module rr_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	output rr_pkg::cmd_t       cmd,
	input  wire rr_pkg::sts_t  sts
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_GCD  = 3'd1;
	localparam logic [2:0] S_DIVN = 3'd2;
	localparam logic [2:0] S_DSW  = 3'd3;
	localparam logic [2:0] S_DIVD = 3'd4;
	localparam logic [2:0] S_FIN  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_GCD;
				end
			end
			S_GCD: begin
				if (sts.err) begin
					state_d = S_FIN;
				end else if (sts.gcd_done) begin
					cmd.gcd_fin = 1'b1;
					state_d     = S_DIVN;
				end else begin
					cmd.gcd_step = 1'b1;
				end
			end
			S_DIVN: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) state_d = S_DSW;
			end
			S_DSW: begin
				cmd.div_init_den = 1'b1;
				state_d          = S_DIVD;
			end
			S_DIVD: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) state_d = S_FIN;
			end
			S_FIN: begin
				// hold until the output register is free or being emptied
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("output register overwritten while holding a result");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_GCD))
		else $error("accepted transaction did not start the GCD");

	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.gcd_step, cmd.gcd_fin, cmd.div_step,
			cmd.div_init_den, cmd.out_load}))
		else $error("conflicting datapath commands");

	a_out_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !cmd.out_load) |=> !out_valid)
		else $error("result delivered twice");

endmodule

`default_nettype wire

// File: design/rr_dp.sv
// Datapath of the fraction reducer: binary GCD, shared restoring divider,
// sign fix-up and output register. Depends on rr_pkg.
`default_nettype none

module rr_dp #(
	parameter int unsigned WIDTH = 32
) (
	input  wire logic                    clk,
	input  wire logic signed [WIDTH-1:0] num_in,
	input  wire logic signed [WIDTH-1:0] den_in,
	output logic signed [WIDTH-1:0]      num_out,
	output logic [WIDTH-2:0]             den_out,
	output logic [rr_pkg::STATUS_W-1:0]  status,
	input  wire rr_pkg::cmd_t            cmd,
	output rr_pkg::sts_t                 sts
);

	localparam int unsigned M  = WIDTH - 1;
	localparam int unsigned CW = $clog2(M);
	localparam logic [CW-1:0] LAST_STEP = CW'(M - 1);

	logic [WIDTH-1:0] n_raw, d_raw, n_neg, d_neg, most_neg;
	logic [M-1:0]     n_mag, d_mag;

	logic                        n_sign_q, d_sign_q;
	logic [rr_pkg::STATUS_W-1:0] code_q;
	logic [M-1:0]                an_q, ad_q, a_q, b_q, g_q, rem_q, quo_q, qn_q;
	logic [CW-1:0]               k_q, cnt_q;

	logic [M:0]   trial;
	logic         fits;
	logic [M-1:0] rem_d;
	logic         neg;
	logic [WIDTH-1:0] qn_ext;

	assign n_raw    = num_in;
	assign d_raw    = den_in;
	assign most_neg = {1'b1, {M{1'b0}}};
	assign n_neg    = (~n_raw) + WIDTH'(1);
	assign d_neg    = (~d_raw) + WIDTH'(1);
	assign n_mag    = n_raw[WIDTH-1] ? n_neg[M-1:0] : n_raw[M-1:0];
	assign d_mag    = d_raw[WIDTH-1] ? d_neg[M-1:0] : d_raw[M-1:0];

	assign trial = {rem_q, quo_q[M-1]};
	assign fits  = (trial >= {1'b0, g_q});
	assign rem_d = fits ? M'(trial - {1'b0, g_q}) : trial[M-1:0];

	assign sts.err      = (code_q != rr_pkg::STATUS_OK);
	assign sts.gcd_done = (a_q == '0) || (b_q == '0);
	assign sts.div_last = (cnt_q == LAST_STEP);

	assign neg    = (n_sign_q ^ d_sign_q) && (qn_q != '0);
	assign qn_ext = {1'b0, qn_q};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_sign_q <= n_raw[WIDTH-1];
			d_sign_q <= d_raw[WIDTH-1];
			an_q     <= n_mag;
			ad_q     <= d_mag;
			a_q      <= n_mag;
			b_q      <= d_mag;
			k_q      <= '0;
			if (d_raw == '0) code_q <= rr_pkg::STATUS_ZERO_DEN;
			else if (n_raw == most_neg || d_raw == most_neg) code_q <= rr_pkg::STATUS_MOST_NEG;
			else code_q <= rr_pkg::STATUS_OK;
		end

		if (cmd.gcd_step) begin
			if (!a_q[0] && !b_q[0]) begin
				a_q <= a_q >> 1;
				b_q <= b_q >> 1;
				k_q <= k_q + CW'(1);
			end else if (!a_q[0]) begin
				a_q <= a_q >> 1;
			end else if (!b_q[0]) begin
				b_q <= b_q >> 1;
			end else if (a_q >= b_q) begin
				a_q <= a_q - b_q;
			end else begin
				b_q <= b_q - a_q;
			end
		end

		if (cmd.gcd_fin) begin
			g_q   <= (a_q | b_q) << k_q;
			rem_q <= '0;
			quo_q <= an_q;
			cnt_q <= '0;
		end

		if (cmd.div_step) begin
			rem_q <= rem_d;
			quo_q <= {quo_q[M-2:0], fits};
			cnt_q <= cnt_q + CW'(1);
		end

		if (cmd.div_init_den) begin
			qn_q  <= quo_q;
			rem_q <= '0;
			quo_q <= ad_q;
			cnt_q <= '0;
		end

		if (cmd.out_load) begin
			status <= code_q;
			if (code_q != rr_pkg::STATUS_OK) begin
				num_out <= '0;
				den_out <= '0;
			end else begin
				num_out <= neg ? ((~qn_ext) + WIDTH'(1)) : qn_ext;
				den_out <= quo_q;
			end
		end
	end

endmodule

`default_nettype wire

// File: design/rational_reduce.sv
// Fraction reducer, top level: controller rr_ctrl plus datapath rr_dp (rr_pkg).
// Sequence: error cases go from acceptance through S_GCD and S_FIN to the output register;
// otherwise the binary GCD loop, the numerator division, S_DSW, the denominator division
// and S_FIN come before it. Throughput: one transaction at a time, as in_ready is high
// only when idle; the GCD loop and the shared one-bit-a-cycle divider, run twice, set the rate.
// Reset: arst_n clears the controller state and the output valid; payload is not reset.
`default_nettype none

module rational_reduce #(
	parameter int unsigned WIDTH = 32
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic signed [WIDTH-1:0] num_in,
	input  wire logic signed [WIDTH-1:0] den_in,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic signed [WIDTH-1:0]      num_out,
	output logic [WIDTH-2:0]             den_out,
	output logic [rr_pkg::STATUS_W-1:0]  status
);

	// command and status between the sequencer and the arithmetic
	rr_pkg::cmd_t cmd;
	rr_pkg::sts_t sts;

	// The controller accepts a transaction only when idle, walks the GCD loop,
	// runs the numerator and then the denominator division on one divider, and
	// hands the result to the output register once that register is free.
	rr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// The datapath flags a zero denominator first, then a most negative input;
	// both skip the arithmetic and give a zero fraction with the error status.
	rr_dp #(
		.WIDTH (WIDTH)
	) u_dp (
		.clk     (clk),
		.num_in  (num_in),
		.den_in  (den_in),
		.num_out (num_out),
		.den_out (den_out),
		.status  (status),
		.cmd     (cmd),
		.sts     (sts)
	);

endmodule

`default_nettype wire

// File: test/testbench.sv
// Self-checking testbench for rational_reduce: drives signed fractions and checks each
// reduced result against an in-bench predictor, with random idle on both handshakes.
// Depends on rr_pkg (status codes) and the rational_reduce top level.
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned W = 32;
	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam int unsigned DRAIN_CYCLES = 150;    // a little over the worst reduction
	localparam int unsigned MAX_REPORTS = 10;

	localparam logic signed [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};
	localparam logic signed [W-1:0] MAX_POS  = {1'b0, {(W-1){1'b1}}};

	// one reduced fraction, plus the operands that produced it for reporting
	typedef struct {
		logic signed [W-1:0]         num;
		logic [W-2:0]                den;
		logic [rr_pkg::STATUS_W-1:0] status;
		logic signed [W-1:0]         src_num;
		logic signed [W-1:0]         src_den;
	} reduced_t;

	logic                         clk;
	logic                         arst_n;
	logic                         in_valid;
	logic                         in_ready;
	logic signed [W-1:0]          num_in;
	logic signed [W-1:0]          den_in;
	logic                         out_valid;
	logic                         out_ready;
	logic signed [W-1:0]          num_out;
	logic [W-2:0]                 den_out;
	logic [rr_pkg::STATUS_W-1:0]  status;

	reduced_t pending_fractions[$];   // reductions accepted but not yet seen at the output

	bit          idle_on = 1'b1;      // random gaps and stalls allowed
	int unsigned cycle_count = 0;
	int unsigned error_count = 0;
	int unsigned items_sent = 0;
	int unsigned results_seen = 0;
	int unsigned ok_seen = 0;
	int unsigned zero_den_seen = 0;
	int unsigned most_neg_seen = 0;

	rational_reduce #(
		.WIDTH(W)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.num_in   (num_in),
		.den_in   (den_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.num_out  (num_out),
		.den_out  (den_out),
		.status   (status)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Predict the reduced fraction: zero denominator wins over the most negative value,
	// then divide both magnitudes by their GCD and put the sign on the numerator.
	function automatic reduced_t reduce_fraction(input logic signed [W-1:0] n,
			input logic signed [W-1:0] d);
		reduced_t r;
		logic [W-1:0] mag_n, mag_d, a, b, t;
		logic         neg;
		r.num = '0;
		r.den = '0;
		r.status = rr_pkg::STATUS_OK;
		r.src_num = n;
		r.src_den = d;
		if (d == '0) begin
			r.status = rr_pkg::STATUS_ZERO_DEN;
		end else if (n == MOST_NEG || d == MOST_NEG) begin
			r.status = rr_pkg::STATUS_MOST_NEG;
		end else begin
			mag_n = n[W-1] ? (~n + 1'b1) : n;
			mag_d = d[W-1] ? (~d + 1'b1) : d;
			// Euclid on the magnitudes; mag_d is nonzero here, so the GCD is too
			a = mag_n;
			b = mag_d;
			while (b != '0) begin
				t = a % b;
				a = b;
				b = t;
			end
			mag_n = mag_n / a;
			mag_d = mag_d / a;
			neg = (n[W-1] ^ d[W-1]) && (mag_n != '0);
			r.num = neg ? (~mag_n + 1'b1) : mag_n;
			r.den = mag_d[W-2:0];
		end
		return r;
	endfunction

	function automatic logic signed [W-1:0] apply_sign(input logic [W-1:0] mag,
			input bit neg);
		return neg ? (~mag + 1'b1) : mag;
	endfunction

	// Draw an operand from the corner values, with plain random words mixed in.
	function automatic logic signed [W-1:0] pick_edge_value();
		logic [W-1:0] v;
		v = '0;
		case ($urandom_range(0, 9))
			0: v = '0;
			1: v = 1;
			2: v = '1;
			3: v = MAX_POS;
			4: v = ~MAX_POS + 1'b1;
			5: v = MOST_NEG;
			6: begin
				v[$urandom_range(0, W-2)] = 1'b1;
				v = apply_sign(v, 1'($urandom_range(0, 1)));
			end
			7: v = apply_sign($urandom_range(1, 64), 1'($urandom_range(0, 1)));
			default: v = $urandom;
		endcase
		return v;
	endfunction

	// Build a pair sharing a random factor, sized so neither product overflows.
	task automatic make_common_pair(output logic signed [W-1:0] n,
			output logic signed [W-1:0] d);
		int unsigned gbits, abits;
		logic [W-1:0] g, a, b;
		gbits = $urandom_range(0, 24);
		g = ($urandom_range(0, 3) == 0) ? (32'd1 << gbits) : $urandom_range(1, 32'd1 << gbits);
		abits = $urandom_range(0, 30 - gbits);
		a = ($urandom_range(0, 15) == 0) ? '0 : $urandom_range(1, 32'd1 << abits);
		b = $urandom_range(1, 32'd1 << abits);
		n = apply_sign(a * g, 1'($urandom_range(0, 1)));
		d = apply_sign(b * g, 1'($urandom_range(0, 1)));
	endtask

	// Offer one transaction, optionally after an idle burst, and hold it until accepted.
	task automatic send_fraction(input logic signed [W-1:0] n, input logic signed [W-1:0] d);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		in_valid <= 1'b1;
		num_in   <= n;
		den_in   <= d;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		// accepted at this edge: record what the block owes us
		pending_fractions.push_back(reduce_fraction(n, d));
		items_sent++;
	endtask

	// Corner cases: zero numerator, zero denominator (also with the most negative
	// numerator), the most negative value on either side, sign moves and extremes.
	task automatic test_special_cases();
		send_fraction(0, 1);
		send_fraction(0, -5);
		send_fraction(0, MAX_POS);
		send_fraction(5, 0);
		send_fraction(0, 0);
		send_fraction(MOST_NEG, 0);
		send_fraction(MOST_NEG, 3);
		send_fraction(3, MOST_NEG);
		send_fraction(MOST_NEG, MOST_NEG);
		send_fraction(0, MOST_NEG);
		send_fraction(MAX_POS, MAX_POS);
		send_fraction(MAX_POS, -1);
		send_fraction(-MAX_POS, MAX_POS);
		send_fraction(-MAX_POS, -MAX_POS);
		send_fraction(MAX_POS, MAX_POS - 1);
		send_fraction(1, MAX_POS);
		send_fraction(-1, MAX_POS);
		send_fraction(1, 1);
		send_fraction(-1, -1);
		send_fraction(6, -4);
		send_fraction(-6, 4);
		send_fraction(12, 18);
		send_fraction(32'sh4000_0000, -32'sh4000_0000);
		send_fraction(32'sh5555_5555, 32'sh2AAA_AAAA);
	endtask

	// Unconstrained words: every operand bit toggles, most pairs are coprime.
	task automatic test_full_range(input int unsigned count);
		repeat (count) send_fraction($urandom, $urandom);
	endtask

	// Pairs with a large shared factor exercise long GCD runs and real division.
	task automatic test_common_factors(input int unsigned count);
		logic signed [W-1:0] n, d;
		repeat (count) begin
			make_common_pair(n, d);
			send_fraction(n, d);
		end
	endtask

	// Corner values against each other, which also hits both error statuses.
	task automatic test_edge_mix(input int unsigned count);
		repeat (count) send_fraction(pick_edge_value(), pick_edge_value());
	endtask

	// Back-to-back transactions with both sides always ready.
	task automatic test_back_to_back(input int unsigned count);
		logic signed [W-1:0] n, d;
		idle_on = 1'b0;
		repeat (count) begin
			case ($urandom_range(0, 3))
				0: make_common_pair(n, d);
				1: begin
					n = pick_edge_value();
					d = pick_edge_value();
				end
				default: begin
					n = $urandom;
					d = $urandom;
				end
			endcase
			send_fraction(n, d);
		end
	endtask

	// Receiver: alternate ready stretches with stall bursts while idling is on.
	initial begin
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (idle_on && $urandom_range(0, 2) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 30)) @(posedge clk);
		end
	end

	// Check every accepted result against the oldest pending reduction.
	always @(posedge clk) begin : check_results
		reduced_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			case (status)
				rr_pkg::STATUS_OK:       ok_seen++;
				rr_pkg::STATUS_ZERO_DEN: zero_den_seen++;
				rr_pkg::STATUS_MOST_NEG: most_neg_seen++;
				default: ;
			endcase
			if (pending_fractions.size() == 0) begin
				error_count++;
				if (error_count <= MAX_REPORTS)
					$display("unexpected result %0d/%0d status %0d at cycle %0d",
						num_out, den_out, status, cycle_count);
			end else begin
				want = pending_fractions.pop_front();
				if (num_out !== want.num || den_out !== want.den || status !== want.status) begin
					error_count++;
					if (error_count <= MAX_REPORTS)
						$display("mismatch for %0d/%0d: expected %0d/%0d status %0d, %s",
							want.src_num, want.src_den, want.num, want.den, want.status,
							$sformatf("got %0d/%0d status %0d", num_out, den_out, status));
				end
			end
		end
	end

	// Watchdog: stop a hung run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still pending",
				cycle_count, pending_fractions.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		arst_n   <= 1'b0;
		in_valid <= 1'b0;
		num_in   <= '0;
		den_in   <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		test_special_cases();
		test_full_range(500);
		test_common_factors(800);
		test_edge_mix(400);
		test_back_to_back(300);

		in_valid <= 1'b0;
		// drain the pipeline, then give the block time to show any stray result
		while (pending_fractions.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d transactions, %0d results checked:",
			items_sent, results_seen);
		$display("  %0d reduced, %0d zero denominator, %0d most negative",
			ok_seen, zero_den_seen, most_neg_seen);
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("%0d mismatching results", error_count);
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

`default_nettype wire
